[rtl/cia_pkg.sv]
package cia_pkg;

  localparam int DW    = 64;
  localparam int CNT_W = $clog2(DW);

  localparam logic [DW-1:0] WORD_ZERO = {DW{1'b0}};
  localparam logic [DW-1:0] WORD_ONE  = {{(DW-1){1'b0}}, 1'b1};
  localparam logic [DW-1:0] WORD_NEG1 = {DW{1'b1}};
  localparam logic [DW-1:0] WORD_MAX  = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] WORD_MIN  = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic [2:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_DIV = 3'd3,
    KIND_MOD = 3'd4,
    KIND_POW = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_DIVZERO  = 2'd2,
    ST_NEGEXP   = 2'd3
  } status_t;

endpackage

[rtl/cia_if.sv]
interface cia_cmd_if;
  import cia_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [2:0]           kind;
  logic signed [DW-1:0] operand_a;
  logic signed [DW-1:0] operand_b;

  modport source (output valid, kind, operand_a, operand_b, input ready);
  modport sink (input valid, kind, operand_a, operand_b, output ready);
endinterface

interface cia_rsp_if;
  import cia_pkg::*;

  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] result_value;
  logic [1:0]           status;

  modport source (output valid, result_value, status, input ready);
  modport sink (input valid, result_value, status, output ready);
endinterface

[rtl/checked_integer_alu.sv]
// Add and subtract are computed in the dispatch state. Multiply, floor divide and floor
// modulo step the shared 65-bit adder through all 64 bits as a shift-add multiplier or
// restoring divider. Power runs at most 11 multiplies on the same datapath.
// Throughput: one item at a time; a new transfer is taken once the result is registered.
// Reset: synchronous rst returns the sequencer to idle and drops a pending result.
module checked_integer_alu (
  input logic clk,
  input logic rst,
  cia_cmd_if.sink cmd,
  cia_rsp_if.source rsp
);
  import cia_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_MAG_A,
    S_MAG_B,
    S_MUL,
    S_MUL_SIGN,
    S_DIV,
    S_DIV_FIX,
    S_POW_ACC,
    S_POW_SHIFT,
    S_EMIT
  } state_t;

  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(DW - 1);
  localparam logic [DW-1:0]    EXP_LIMIT = DW'(DW);

  state_t            state;
  logic [2:0]        kind;
  logic [DW-1:0]     ox;
  logic [DW-1:0]     oy;
  logic [DW-1:0]     ma;
  logic [DW-1:0]     mb;
  logic              sa;
  logic              sb;
  logic [DW-1:0]     hi;
  logic [DW-1:0]     lo;
  logic [CNT_W-1:0]  cnt;
  logic [DW-1:0]     acc;
  logic [DW-1:0]     sq;
  logic [DW-1:0]     ex;
  logic              to_acc;
  logic [DW-1:0]     rv;
  status_t           rs;
  logic              out_valid;
  logic [DW-1:0]     out_value;
  status_t           out_status;

  logic [DW:0]       add_x;
  logic [DW:0]       add_y;
  logic              add_cin;
  logic [DW:0]       add_sum;
  logic              differ;
  logic              rem_zero;
  logic              mul_ovf;
  logic              is_divmod;
  logic [DW-1:0]     mag_b;

  assign cmd.ready        = (state == S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.result_value = out_value;
  assign rsp.status       = out_status;

  assign differ    = sa ^ sb;
  assign rem_zero  = (hi == WORD_ZERO);
  assign mul_ovf   = (hi != WORD_ZERO) ||
                     (lo[DW-1] && !(differ && (lo[DW-2:0] == WORD_ZERO[DW-2:0])));
  assign is_divmod = (kind == KIND_DIV) || (kind == KIND_MOD);
  assign mag_b     = oy[DW-1] ? add_sum[DW-1:0] : oy;

  // shared adder
  assign add_sum = add_x + add_y + (DW+1)'(add_cin);

  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_cin = 1'b0;
    unique case (state)
      S_DISPATCH: begin
        add_x   = {ox[DW-1], ox};
        add_y   = (kind == KIND_SUB) ? ~{oy[DW-1], oy} : {oy[DW-1], oy};
        add_cin = (kind == KIND_SUB);
      end
      S_MAG_A: begin
        add_y   = {1'b0, ~ox};
        add_cin = 1'b1;
      end
      S_MAG_B: begin
        add_y   = {1'b0, ~oy};
        add_cin = 1'b1;
      end
      S_MUL: begin
        add_x = {1'b0, hi};
        add_y = lo[0] ? {1'b0, ma} : '0;
      end
      S_MUL_SIGN: begin
        add_y   = {1'b0, differ ? ~lo : lo};
        add_cin = differ;
      end
      S_DIV: begin
        add_x   = {1'b0, hi[DW-2:0], lo[DW-1]};
        add_y   = ~{1'b0, mb};
        add_cin = 1'b1;
      end
      S_DIV_FIX: begin
        if (kind == KIND_DIV) begin
          add_y   = {1'b0, differ ? ~lo : lo};
          add_cin = differ && rem_zero;
        end else begin
          add_x   = {1'b0, (differ && !rem_zero) ? oy : WORD_ZERO};
          add_y   = {1'b0, sa ? ~hi : hi};
          add_cin = sa;
        end
      end
      default: begin
        add_cin = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            kind  <= cmd.kind;
            ox    <= cmd.operand_a;
            oy    <= cmd.operand_b;
            ex    <= cmd.operand_b;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          rv    <= WORD_ZERO;
          rs    <= ST_OK;
          state <= S_EMIT;
          case (kind) inside
            KIND_ADD, KIND_SUB: begin
              if (add_sum[DW] != add_sum[DW-1]) begin
                rs <= ST_OVERFLOW;
              end else begin
                rv <= add_sum[DW-1:0];
              end
            end
            KIND_MUL: begin
              state <= S_MAG_A;
            end
            KIND_DIV, KIND_MOD: begin
              if (oy == WORD_ZERO) begin
                rs <= ST_DIVZERO;
              end else if (kind == KIND_DIV && ox == WORD_MIN && oy == WORD_NEG1) begin
                rs <= ST_OVERFLOW;
              end else begin
                state <= S_MAG_A;
              end
            end
            KIND_POW: begin
              if (ex[DW-1]) begin
                rs <= ST_NEGEXP;
              end else if (ex == WORD_ZERO) begin
                rv <= WORD_ONE;
              end else if (ox == WORD_ZERO) begin
                rv <= WORD_ZERO;
              end else if (ox == WORD_ONE) begin
                rv <= WORD_ONE;
              end else if (ox == WORD_NEG1) begin
                rv <= ex[0] ? WORD_NEG1 : WORD_ONE;
              end else if (ex >= EXP_LIMIT) begin
                rs <= ST_OVERFLOW;
              end else begin
                acc   <= WORD_ONE;
                sq    <= ox;
                state <= S_POW_ACC;
              end
            end
            default: begin
              rv <= WORD_ZERO;
            end
          endcase
        end
        S_MAG_A: begin
          ma    <= ox[DW-1] ? add_sum[DW-1:0] : ox;
          sa    <= ox[DW-1];
          state <= S_MAG_B;
        end
        S_MAG_B: begin
          mb  <= mag_b;
          sb  <= oy[DW-1];
          hi  <= WORD_ZERO;
          cnt <= '0;
          if (is_divmod) begin
            lo    <= ma;
            state <= S_DIV;
          end else begin
            lo    <= mag_b;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          hi  <= add_sum[DW:1];
          lo  <= {add_sum[0], lo[DW-1:1]};
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_LAST) begin
            state <= S_MUL_SIGN;
          end
        end
        S_MUL_SIGN: begin
          if (mul_ovf) begin
            rv    <= WORD_ZERO;
            rs    <= ST_OVERFLOW;
            state <= S_EMIT;
          end else if (kind == KIND_POW) begin
            if (to_acc) begin
              acc   <= add_sum[DW-1:0];
              state <= S_POW_SHIFT;
            end else begin
              sq    <= add_sum[DW-1:0];
              state <= S_POW_ACC;
            end
          end else begin
            rv    <= add_sum[DW-1:0];
            rs    <= ST_OK;
            state <= S_EMIT;
          end
        end
        S_DIV: begin
          hi  <= add_sum[DW] ? {hi[DW-2:0], lo[DW-1]} : add_sum[DW-1:0];
          lo  <= {lo[DW-2:0], !add_sum[DW]};
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_LAST) begin
            state <= S_DIV_FIX;
          end
        end
        S_DIV_FIX: begin
          rv    <= add_sum[DW-1:0];
          rs    <= ST_OK;
          state <= S_EMIT;
        end
        S_POW_ACC: begin
          if (ex[0]) begin
            ox     <= acc;
            oy     <= sq;
            to_acc <= 1'b1;
            state  <= S_MAG_A;
          end else begin
            state <= S_POW_SHIFT;
          end
        end
        S_POW_SHIFT: begin
          ex <= {1'b0, ex[DW-1:1]};
          if (ex[DW-1:1] == WORD_ZERO[DW-2:0]) begin
            rv    <= acc;
            rs    <= ST_OK;
            state <= S_EMIT;
          end else begin
            ox     <= sq;
            oy     <= sq;
            to_acc <= 1'b0;
            state  <= S_MAG_A;
          end
        end
        S_EMIT: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_value  <= rv;
            out_status <= rs;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/cia_checker.sv]
module cia_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        cmd_valid,
  input logic                        cmd_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [cia_pkg::DW-1:0]      rsp_value,
  input logic [1:0]                  rsp_status
);
  import cia_pkg::*;

  // hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_value) && $stable(rsp_status))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_value == WORD_ZERO)
    else $error("nonzero value with error status");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("second transfer taken while busy");

endmodule

bind checked_integer_alu cia_checker u_cia_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_value  (rsp.result_value),
  .rsp_status (rsp.status)
);
